### sv/tsp2cb_pkg.sv
// Shared constants and types for the two-cheapest-edge bound block.
// No dependencies; row_bound, out_stage and the top refer to it by scoped names, the bench imports it.
`default_nettype none

package tsp2cb_pkg;

    localparam int MAX_CITIES_DEFAULT = 256;
    localparam int DIST_BITS_DEFAULT  = 24;

    localparam int NUM_CITIES_BITS = 9;
    localparam int SUM_BITS        = 34;
    localparam int BOUND_BITS      = 33;
    localparam int MIN_CITIES      = 2;

    localparam logic [NUM_CITIES_BITS-1:0] NUM_CITIES_RESET = NUM_CITIES_BITS'(MIN_CITIES);

    localparam logic [1:0] MARK_FREE     = 2'd0;
    localparam logic [1:0] MARK_INCLUDED = 2'd1;
    localparam logic [1:0] MARK_EXCLUDED = 2'd2;

    localparam logic [1:0] INCL_NONE = 2'd0;
    localparam logic [1:0] INCL_ONE  = 2'd1;
    localparam logic [1:0] INCL_TWO  = 2'd2;
    localparam logic [1:0] INCL_SAT  = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [BOUND_BITS-1:0] bound;
    } result_t;

endpackage

`default_nettype wire

### sv/tsp2cb_in_stage.sv
// Input register for distance items with valid/stall handshake.
// Depends on nothing but its parameter; feeds tsp2cb_row_bound.
`default_nettype none

module tsp2cb_in_stage #(
    parameter int DIST_BITS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DIST_BITS-1:0] distance,
    input  wire logic [1:0]           edge_mark,
    input  wire logic                 blocked,
    output logic                      item_go,
    output logic [DIST_BITS-1:0]      item_distance,
    output logic [1:0]                item_mark
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [DIST_BITS-1:0] distance_reg;
    logic [1:0]           mark_reg;

    assign in_stall      = valid_reg && blocked;
    assign item_go       = valid_reg && !blocked;
    assign item_distance = distance_reg;
    assign item_mark     = mark_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            distance_reg <= distance;
            mark_reg     <= edge_mark;
        end
    end

    stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid_reg)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire

### sv/tsp2cb_row_bound.sv
// Row tracking of the two cheapest free and first two included edges,
// and the saturating bound accumulator. Uses tsp2cb_pkg.
`default_nettype none

module tsp2cb_row_bound #(
    parameter int MAX_CITIES = 256,
    parameter int DIST_BITS  = 24
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_go,
    input  wire logic [tsp2cb_pkg::NUM_CITIES_BITS-1:0]    cfg_num,
    input  wire logic                                      item_go,
    input  wire logic [DIST_BITS-1:0]                      item_distance,
    input  wire logic [1:0]                                item_mark,
    output tsp2cb_pkg::result_t                            result
);

    localparam int IW = (MAX_CITIES > 2) ? $clog2(MAX_CITIES) : 1;
    localparam logic [DIST_BITS-1:0] DIST_NONE = {DIST_BITS{1'b1}};
    localparam int SB = tsp2cb_pkg::SUM_BITS;
    localparam int BB = tsp2cb_pkg::BOUND_BITS;

    logic [IW-1:0]        last_reg, last_next;
    logic [IW-1:0]        col_reg, col_next;
    logic [IW-1:0]        row_reg, row_next;
    logic [DIST_BITS-1:0] cheap_reg, cheap_next;
    logic [DIST_BITS-1:0] second_reg, second_next;
    logic [1:0]           incl_cnt_reg, incl_cnt_next;
    logic [DIST_BITS-1:0] incl_a_reg, incl_a_next;
    logic [DIST_BITS-1:0] incl_b_reg, incl_b_next;
    logic [SB-1:0]        sum_reg, sum_next;

    logic                 diag;
    logic [DIST_BITS-1:0] incl_val;
    logic [DIST_BITS-1:0] pick_a;
    logic [DIST_BITS-1:0] pick_b;
    logic [DIST_BITS-1:0] cost_a;
    logic [DIST_BITS-1:0] cost_b;
    logic [SB:0]          sum_wide;
    logic [SB-1:0]        sum_sat;
    logic [31:0]          cfg_wide;
    logic [31:0]          cfg_dim;

    always_comb
    begin
        cfg_wide = 32'(cfg_num);
        priority if (cfg_wide < 32'(tsp2cb_pkg::MIN_CITIES))
        begin
            cfg_dim = 32'(tsp2cb_pkg::MIN_CITIES);
        end
        else if (cfg_wide > 32'(MAX_CITIES))
        begin
            cfg_dim = 32'(MAX_CITIES);
        end
        else
        begin
            cfg_dim = cfg_wide;
        end
    end

    always_comb
    begin
        last_next     = last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cheap_next    = cheap_reg;
        second_next   = second_reg;
        incl_cnt_next = incl_cnt_reg;
        incl_a_next   = incl_a_reg;
        incl_b_next   = incl_b_reg;
        sum_next      = sum_reg;
        result.valid  = 1'b0;
        result.bound  = '0;
        pick_a        = '0;
        pick_b        = '0;
        cost_a        = '0;
        cost_b        = '0;
        sum_wide      = '0;
        sum_sat       = '0;

        diag     = (col_reg == row_reg);
        incl_val = diag ? DIST_NONE : item_distance;

        if (cfg_go)
        begin
            last_next     = IW'(cfg_dim - 32'd1);
            col_next      = '0;
            row_next      = '0;
            sum_next      = '0;
            cheap_next    = DIST_NONE;
            second_next   = DIST_NONE;
            incl_cnt_next = tsp2cb_pkg::INCL_NONE;
            incl_a_next   = DIST_NONE;
            incl_b_next   = DIST_NONE;
        end
        else if (item_go)
        begin
            if (item_mark == tsp2cb_pkg::MARK_INCLUDED)
            begin
                if (incl_cnt_reg == tsp2cb_pkg::INCL_NONE)
                begin
                    incl_a_next = incl_val;
                end
                else if (incl_cnt_reg == tsp2cb_pkg::INCL_ONE)
                begin
                    incl_b_next = incl_val;
                end
                if (incl_cnt_reg != tsp2cb_pkg::INCL_SAT)
                begin
                    incl_cnt_next = incl_cnt_reg + 2'd1;
                end
            end
            else if (item_mark != tsp2cb_pkg::MARK_EXCLUDED && !diag)
            begin
                priority if (item_distance < cheap_reg)
                begin
                    second_next = cheap_reg;
                    cheap_next  = item_distance;
                end
                else if (item_distance < second_reg)
                begin
                    second_next = item_distance;
                end
            end

            if (col_reg == last_reg)
            begin
                priority if (incl_cnt_next == tsp2cb_pkg::INCL_TWO)
                begin
                    pick_a = incl_a_next;
                    pick_b = incl_b_next;
                end
                else if (incl_cnt_next == tsp2cb_pkg::INCL_ONE)
                begin
                    pick_a = incl_a_next;
                    pick_b = cheap_next;
                end
                else
                begin
                    pick_a = cheap_next;
                    pick_b = second_next;
                end
                cost_a   = (pick_a == DIST_NONE) ? '0 : pick_a;
                cost_b   = (pick_b == DIST_NONE) ? '0 : pick_b;
                sum_wide = {1'b0, sum_reg} + (SB+1)'(cost_a) + (SB+1)'(cost_b);
                sum_sat  = sum_wide[SB] ? {SB{1'b1}} : sum_wide[SB-1:0];

                cheap_next    = DIST_NONE;
                second_next   = DIST_NONE;
                incl_cnt_next = tsp2cb_pkg::INCL_NONE;
                incl_a_next   = DIST_NONE;
                incl_b_next   = DIST_NONE;
                col_next      = '0;

                if (row_reg == last_reg)
                begin
                    result.valid = 1'b1;
                    result.bound = sum_sat[SB-1] ? {BB{1'b1}} : sum_sat[BB-1:0];
                    sum_next     = '0;
                    row_next     = '0;
                end
                else
                begin
                    sum_next = sum_sat;
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= IW'(tsp2cb_pkg::MIN_CITIES - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            cheap_reg    <= DIST_NONE;
            second_reg   <= DIST_NONE;
            incl_cnt_reg <= tsp2cb_pkg::INCL_NONE;
            incl_a_reg   <= DIST_NONE;
            incl_b_reg   <= DIST_NONE;
            sum_reg      <= '0;
        end
        else
        begin
            last_reg     <= last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            cheap_reg    <= cheap_next;
            second_reg   <= second_next;
            incl_cnt_reg <= incl_cnt_next;
            incl_a_reg   <= incl_a_next;
            incl_b_reg   <= incl_b_next;
            sum_reg      <= sum_next;
        end
    end

    restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_go |=> (col_reg == '0 && row_reg == '0 && sum_reg == '0))
        else $error("restart left counters or sum set");

    column_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_reg) && (row_reg <= last_reg))
        else $error("index beyond matrix dimension");

    free_order: assert property (@(posedge clk) disable iff (!rst_n)
        cheap_reg <= second_reg)
        else $error("cheapest free edge above second");

endmodule

`default_nettype wire

### sv/tsp2cb_out_stage.sv
// Result register holding the bound until the receiver takes it.
// Uses tsp2cb_pkg::result_t from tsp2cb_row_bound.
`default_nettype none

module tsp2cb_out_stage (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tsp2cb_pkg::result_t                  result,
    output logic                                      blocked,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [tsp2cb_pkg::BOUND_BITS-1:0]         bound_halves
);

    logic                              valid_reg;
    logic                              valid_next;
    logic [tsp2cb_pkg::BOUND_BITS-1:0] bound_reg;

    assign blocked      = valid_reg && out_stall;
    assign out_valid    = valid_reg;
    assign bound_halves = bound_reg;

    always_comb
    begin
        valid_next = valid_reg;
        priority if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            bound_reg <= result.bound;
        end
    end

    no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(result.valid && valid_reg && out_stall))
        else $error("result arrived over a held result");

endmodule

`default_nettype wire

### sv/tsp_two_cheapest_edge_bound_top.sv
// Two-cheapest-edge lower bound for one branch-and-bound node.
// Instantiates tsp2cb_in_stage, tsp2cb_row_bound, tsp2cb_out_stage; uses tsp2cb_pkg.
//
// Usage:
//   Write num_cities on the cfg channel (cfg_ready is always high) while idle;
//   the write restarts the matrix. Then stream the N x N matrix row by row,
//   one element (distance, edge_mark) per item on in_valid/in_stall.
//   After the last element one item carries bound_halves, the bound times two,
//   on out_valid/out_stall. No other item is produced.
// Timing:
//   One item per cycle sustained while no result waits under out_stall. The
//   row update and accumulator act on the input register, and the bound for the
//   last element lands in the result register, where out_valid offers it.
// Reset:
//   rst_n clears both registers' valid flags and returns num_cities to 2
//   with empty row state and a zero sum.
// Stall:
//   While a result waits under out_stall, the input register still fills;
//   an element already held there waits, and in_stall rises, until the
//   result is taken.
`default_nettype none

module tsp_two_cheapest_edge_bound_top #(
    parameter int MAX_CITIES = tsp2cb_pkg::MAX_CITIES_DEFAULT,
    parameter int DIST_BITS  = tsp2cb_pkg::DIST_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tsp2cb_pkg::NUM_CITIES_BITS-1:0] num_cities,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [DIST_BITS-1:0]                   distance,
    input  wire logic [1:0]                             edge_mark,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [tsp2cb_pkg::BOUND_BITS-1:0]           bound_halves
);

    logic                 blocked;
    logic                 item_go;
    logic [DIST_BITS-1:0] item_distance;
    logic [1:0]           item_mark;
    tsp2cb_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    tsp2cb_in_stage #(
        .DIST_BITS (DIST_BITS)
    ) u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .distance      (distance),
        .edge_mark     (edge_mark),
        .blocked       (blocked),
        .item_go       (item_go),
        .item_distance (item_distance),
        .item_mark     (item_mark)
    );

    tsp2cb_row_bound #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) u_row (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_go        (cfg_valid && cfg_ready),
        .cfg_num       (num_cities),
        .item_go       (item_go),
        .item_distance (item_distance),
        .item_mark     (item_mark),
        .result        (result)
    );

    tsp2cb_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .blocked      (blocked),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bound_halves (bound_halves)
    );

endmodule

`default_nettype wire

### sim/tsp_two_cheapest_edge_bound_top_tb.sv
// Self-checking bench for tsp_two_cheapest_edge_bound_top: streams tagged matrices and
// checks each bound against a cycle-free predictor held in a small scoreboard class.
// Depends on tsp2cb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tsp_two_cheapest_edge_bound_top_tb;

    import tsp2cb_pkg::*;

    localparam int                 DIST_W     = 24;
    localparam int                 CITIES_MAX = 256;
    localparam logic [DIST_W-1:0]  DIST_NONE  = {DIST_W{1'b1}};
    localparam logic [1:0]         MARK_SPARE = 2'd3;

    class bound_scoreboard;
        logic [NUM_CITIES_BITS-1:0] cities_reg;
        int unsigned                col;
        int unsigned                row;
        logic [DIST_W-1:0]          cheap1;
        logic [DIST_W-1:0]          cheap2;
        logic [DIST_W-1:0]          incl1;
        logic [DIST_W-1:0]          incl2;
        logic [1:0]                 incl_cnt;
        logic [SUM_BITS-1:0]        bound_acc;
        logic [BOUND_BITS-1:0]      expected_bounds[$];
        int                         errors;

        function new();
            cities_reg = NUM_CITIES_RESET;
            errors     = 0;
            restart_matrix();
        endfunction

        function void clear_row();
            cheap1   = DIST_NONE;
            cheap2   = DIST_NONE;
            incl1    = DIST_NONE;
            incl2    = DIST_NONE;
            incl_cnt = INCL_NONE;
        endfunction

        function void restart_matrix();
            col       = 0;
            row       = 0;
            bound_acc = '0;
            clear_row();
        endfunction

        function void set_cities(logic [NUM_CITIES_BITS-1:0] n);
            cities_reg = n;
            restart_matrix();
        endfunction

        function int unsigned cities_used();
            if (cities_reg < MIN_CITIES)
                return MIN_CITIES;
            if (cities_reg > CITIES_MAX)
                return CITIES_MAX;
            return cities_reg;
        endfunction

        function int pending();
            return expected_bounds.size();
        endfunction

        function void note_element(logic [DIST_W-1:0] d, logic [1:0] m);
            int unsigned           n;
            logic [DIST_W-1:0]     a;
            logic [DIST_W-1:0]     b;
            logic [SUM_BITS+1:0]   total;
            logic [BOUND_BITS-1:0] bound_out;
            n = cities_used();
            if (col >= n)
                col = 0;
            if (row >= n)
                row = 0;
            if (m == MARK_INCLUDED)
            begin
                a = (col == row) ? DIST_NONE : d;
                if (incl_cnt == INCL_NONE)
                    incl1 = a;
                else if (incl_cnt == INCL_ONE)
                    incl2 = a;
                if (incl_cnt != INCL_SAT)
                    incl_cnt = incl_cnt + 2'd1;
            end
            else if (m != MARK_EXCLUDED && col != row)
            begin
                if (d < cheap1)
                begin
                    cheap2 = cheap1;
                    cheap1 = d;
                end
                else if (d < cheap2)
                    cheap2 = d;
            end
            if (col + 1 >= n)
            begin
                case (incl_cnt)
                    INCL_TWO:
                    begin
                        a = incl1;
                        b = incl2;
                    end
                    INCL_ONE:
                    begin
                        a = incl1;
                        b = cheap1;
                    end
                    default:
                    begin
                        a = cheap1;
                        b = cheap2;
                    end
                endcase
                total = (SUM_BITS+2)'(bound_acc)
                      + ((a == DIST_NONE) ? '0 : (SUM_BITS+2)'(a))
                      + ((b == DIST_NONE) ? '0 : (SUM_BITS+2)'(b));
                bound_acc = (total[SUM_BITS+1:SUM_BITS] != 2'b00) ? '1 : total[SUM_BITS-1:0];
                clear_row();
                col = 0;
                if (row + 1 >= n)
                begin
                    if (bound_acc[SUM_BITS-1])
                        bound_out = '1;
                    else
                        bound_out = bound_acc[BOUND_BITS-1:0];
                    expected_bounds = {expected_bounds, bound_out};
                    bound_acc = '0;
                    row       = 0;
                end
                else
                    row++;
            end
            else
                col++;
        endfunction

        function void check_bound(logic [BOUND_BITS-1:0] got);
            logic [BOUND_BITS-1:0] exp_bound;
            if (expected_bounds.size() == 0)
            begin
                $error("bound_halves: expected none, actual %0d", got);
                errors++;
                return;
            end
            exp_bound = expected_bounds.pop_front();
            if (got !== exp_bound)
            begin
                $error("bound_halves: expected %0d, actual %0d", exp_bound, got);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [NUM_CITIES_BITS-1:0] num_cities;
    logic                       in_valid;
    logic                       in_stall;
    logic [DIST_W-1:0]          distance;
    logic [1:0]                 edge_mark;
    logic                       out_valid;
    logic                       out_stall;
    logic [BOUND_BITS-1:0]      bound_halves;

    bound_scoreboard board = new();
    bit              idle_on = 1'b1;
    logic            hold_request;
    int              items_sent = 0;

    tsp_two_cheapest_edge_bound_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .num_cities   (num_cities),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .distance     (distance),
        .edge_mark    (edge_mark),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bound_halves (bound_halves)
    );

    always #4 clk = ~clk;

    function automatic logic [DIST_W-1:0] rand_distance(bit heavy);
        if (heavy)
            return ($urandom_range(0, 49) == 0) ? DIST_NONE
                   : DIST_W'($urandom_range(24'hF00000, 24'hFFFFFE));
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIST_NONE;
            2:       return DIST_NONE - 1'b1;
            3, 4:    return DIST_W'($urandom_range(0, 15));
            default: return DIST_W'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_mark();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return MARK_FREE;
        if (r < 16)
            return MARK_INCLUDED;
        if (r < 19)
            return MARK_EXCLUDED;
        return MARK_SPARE;
    endfunction

    task automatic send_element(input logic [DIST_W-1:0] d, input logic [1:0] m);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        distance  <= d;
        edge_mark <= m;
        do
            @(posedge clk);
        while (in_stall);
        board.note_element(d, m);
        items_sent++;
    endtask

    task automatic send_elements(input int count, input bit heavy);
        repeat (count)
            send_element(rand_distance(heavy), rand_mark());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cities(input logic [NUM_CITIES_BITS-1:0] n);
        drain();
        cfg_valid  <= 1'b1;
        num_cities <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_cities(n);
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall    <= 1'b0;
        hold_request <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_bound(bound_halves);
            if (hold_request)
            begin
                hold_left = 80;
                hold_request <= 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            out_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    initial
    begin
        int n;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        num_cities <= NUM_CITIES_RESET;
        in_valid   <= 1'b0;
        distance   <= '0;
        edge_mark  <= MARK_FREE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dimension, plain free edges, spare mark on the diagonal
        send_element(24'd5, MARK_FREE);
        send_element(24'd7, MARK_FREE);
        send_element(24'd3, MARK_FREE);
        send_element(24'd9, MARK_SPARE);

        // dimension below range; included diagonal and all-ones distances
        write_cities(9'd0);
        send_element(DIST_NONE, MARK_INCLUDED);
        send_element(DIST_NONE - 1'b1, MARK_INCLUDED);
        send_element(DIST_NONE, MARK_FREE);
        send_element(24'd0, MARK_EXCLUDED);

        // zero distances, an excluded edge, one included edge with no free edge
        write_cities(9'd1);
        send_element(24'd0, MARK_FREE);
        send_element(24'd0, MARK_FREE);
        send_element(DIST_NONE - 1'b1, MARK_EXCLUDED);
        send_element(24'h800000, MARK_INCLUDED);

        // three included edges, one included plus free, spare mark off the diagonal
        write_cities(9'd3);
        send_element(24'd11, MARK_INCLUDED);
        send_element(24'd22, MARK_INCLUDED);
        send_element(24'd33, MARK_INCLUDED);
        send_element(24'd44, MARK_INCLUDED);
        send_element(24'd55, MARK_FREE);
        send_element(24'd66, MARK_FREE);
        send_element(24'd77, MARK_EXCLUDED);
        send_element(24'd88, MARK_SPARE);
        send_element(24'd99, MARK_FREE);

        // hold the output long enough to back up the input
        write_cities(9'd2);
        hold_request <= 1'b1;
        send_elements(40, 1'b0);
        drain();

        while (items_sent < 230)
        begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 1);
                1:       n = $urandom_range(7, 8);
                default: n = $urandom_range(2, 6);
            endcase
            write_cities(NUM_CITIES_BITS'(n));
            n = board.cities_used();
            send_elements($urandom_range(1, 2) * n * n, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                send_elements($urandom_range(1, n * n - 1), 1'b0);
        end

        // cut-short matrices at full size and after a large write that clamps
        write_cities(9'd256);
        send_elements(37, 1'b0);
        write_cities(9'd511);
        send_elements(37, 1'b1);

        drain();
        idle_on = 1'b0;
        n = $urandom_range(2, 5);
        write_cities(NUM_CITIES_BITS'(n));
        send_elements(((60 + n * n - 1) / (n * n)) * n * n, 1'b0);

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
sv/tsp2cb_pkg.sv
sv/tsp2cb_in_stage.sv
sv/tsp2cb_row_bound.sv
sv/tsp2cb_out_stage.sv
sv/tsp_two_cheapest_edge_bound_top.sv
sim/tsp_two_cheapest_edge_bound_top_tb.sv
